/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// cond never holds
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* hw/rtl/nvro_pkg.sv */
// Shared types, constants and register codes of the NV21 rectangle overlay.
`default_nettype none

package nvro_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int Y_W         = DIM_W + 1;
   localparam int RECT_W      = 13;
   localparam int COORD_W     = 16;
   localparam int LW_W        = 8;
   localparam int BYTE_W      = 8;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_LEFT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_TOP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_RIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RECT_BOTTOM  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 3'd7;

   localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(480);
   localparam logic [LW_W-1:0]   RST_LINE_WIDTH   = LW_W'(2);

   localparam logic [BYTE_W-1:0] LUMA_BORDER   = BYTE_W'(255);
   localparam logic [BYTE_W-1:0] CHROMA_COLOR  = BYTE_W'(60);
   localparam logic [BYTE_W-1:0] CHROMA_PLAIN  = BYTE_W'(0);

   // geometry pipeline depth, also the input hold-off after a register write
   localparam int GEO_STAGES  = 5;
   localparam int SETTLE_W    = $clog2(GEO_STAGES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic             color_mode;
   } cfg_type;

   // border intervals, all half open
   typedef struct packed {
      logic signed [COORD_W-1:0] top_lo;
      logic signed [COORD_W-1:0] top_hi;
      logic signed [COORD_W-1:0] bot_lo;
      logic signed [COORD_W-1:0] bot_hi;
      logic signed [COORD_W-1:0] bar_lo;
      logic signed [COORD_W-1:0] bar_hi;
      logic signed [COORD_W-1:0] band_lo;
      logic signed [COORD_W-1:0] band_hi;
      logic signed [COORD_W-1:0] left_hi;
      logic signed [COORD_W-1:0] right_lo;
   } geo_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic [DIM_W-1:0]  col;
      logic [DIM_W-1:0]  row;
      logic              chroma;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

   function automatic logic signed [COORD_W-1:0] sext_rect(input logic [RECT_W-1:0] v);
      return COORD_W'(signed'(v));
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/nvro_geometry.sv */
// Configuration registers and the pipeline that derives the border intervals.
`default_nettype none

module nvro_geometry (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [nvro_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [nvro_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output nvro_pkg::cfg_type                      cfg,
   output nvro_pkg::geo_type                      geo,
   output logic                                   settling
);

   localparam int CW = nvro_pkg::COORD_W;

   logic [nvro_pkg::DIM_W-1:0]  width_ff, height_ff;
   logic [nvro_pkg::RECT_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic [nvro_pkg::LW_W-1:0]   lw_ff;
   logic                        color_ff;
   logic [nvro_pkg::SETTLE_W-1:0] settle_ff, settle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nvro_pkg::RST_FRAME_WIDTH;
         height_ff <= nvro_pkg::RST_FRAME_HEIGHT;
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         lw_ff     <= nvro_pkg::RST_LINE_WIDTH;
         color_ff  <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            nvro_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[nvro_pkg::DIM_W-1:0];
            nvro_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[nvro_pkg::DIM_W-1:0];
            nvro_pkg::CSR_RECT_LEFT:    left_ff   <= csr_wdata[nvro_pkg::RECT_W-1:0];
            nvro_pkg::CSR_RECT_TOP:     top_ff    <= csr_wdata[nvro_pkg::RECT_W-1:0];
            nvro_pkg::CSR_RECT_RIGHT:   right_ff  <= csr_wdata[nvro_pkg::RECT_W-1:0];
            nvro_pkg::CSR_RECT_BOTTOM:  bottom_ff <= csr_wdata[nvro_pkg::RECT_W-1:0];
            nvro_pkg::CSR_LINE_WIDTH:   lw_ff     <= csr_wdata[nvro_pkg::LW_W-1:0];
            nvro_pkg::CSR_COLOR_MODE:   color_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // hold-off while the pipeline below refills
   always_comb begin
      settle_in = settle_ff;
      if (csr_wen) begin
         settle_in = nvro_pkg::SETTLE_W'(nvro_pkg::GEO_STAGES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= nvro_pkg::SETTLE_W'(nvro_pkg::GEO_STAGES);
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign settling = (settle_ff != '0);

   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;
   assign cfg.color_mode   = color_ff;

   logic signed [CW-1:0] w_s, h_s, lw_s, half_s;
   assign w_s    = CW'(width_ff);
   assign h_s    = CW'(height_ff);
   assign lw_s   = CW'(lw_ff);
   assign half_s = CW'(lw_ff >> 1);

   // stage 1: intersect with the frame
   logic signed [CW-1:0] s1_l_ff, s1_t_ff, s1_r_ff, s1_b_ff;
   logic signed [CW-1:0] s1_l_in, s1_t_in, s1_r_in, s1_b_in;
   logic signed [CW-1:0] rl_s, rt_s, rr_s, rb_s;

   always_comb begin
      rl_s = nvro_pkg::sext_rect(left_ff);
      rt_s = nvro_pkg::sext_rect(top_ff);
      rr_s = nvro_pkg::sext_rect(right_ff);
      rb_s = nvro_pkg::sext_rect(bottom_ff);
      s1_l_in = (rl_s > 0) ? rl_s : '0;
      s1_t_in = (rt_s > 0) ? rt_s : '0;
      s1_r_in = (rr_s < w_s) ? rr_s : w_s;
      s1_b_in = (rb_s < h_s) ? rb_s : h_s;
   end

   // stage 2: empty check, sizes
   logic signed [CW-1:0] s2_l_ff, s2_t_ff, s2_r_ff, s2_b_ff, s2_rw_ff, s2_rh_ff;
   logic signed [CW-1:0] s2_l_in, s2_t_in, s2_r_in, s2_b_in;
   logic                 empty;

   always_comb begin
      empty   = (s1_l_ff >= s1_r_ff) || (s1_t_ff >= s1_b_ff);
      s2_l_in = empty ? '0 : s1_l_ff;
      s2_t_in = empty ? '0 : s1_t_ff;
      s2_r_in = empty ? '0 : s1_r_ff;
      s2_b_in = empty ? '0 : s1_b_ff;
   end

   // stage 3: first clamp of each edge
   logic signed [CW-1:0] s3_l_ff, s3_t_ff, s3_r_ff, s3_b_ff;
   logic signed [CW-1:0] s3_l_in, s3_t_in, s3_r_in, s3_b_in;

   always_comb begin
      s3_t_in = (s2_t_ff + lw_s + s2_rh_ff > h_s) ? (h_s - lw_s - s2_rh_ff) : s2_t_ff;
      s3_b_in = (s2_b_ff - lw_s < 0) ? lw_s : s2_b_ff;
      s3_l_in = (s2_l_ff + lw_s + s2_rw_ff > w_s) ? (w_s - lw_s - s2_rw_ff) : s2_l_ff;
      s3_r_in = (s2_r_ff - lw_s < 0) ? lw_s : s2_r_ff;
   end

   // stage 4: second clamp
   logic signed [CW-1:0] s4_l_ff, s4_t_ff, s4_r_ff, s4_b_ff;
   logic signed [CW-1:0] s4_l_in, s4_t_in, s4_r_in, s4_b_in;

   always_comb begin
      s4_t_in = (s3_t_ff < half_s) ? half_s : s3_t_ff;
      s4_b_in = (s3_b_ff + half_s > h_s) ? (h_s - half_s) : s3_b_ff;
      s4_l_in = (s3_l_ff < half_s) ? half_s : s3_l_ff;
      s4_r_in = (s3_r_ff + half_s > w_s) ? (w_s - half_s) : s3_r_ff;
   end

   // stage 5: band and bar intervals
   nvro_pkg::geo_type geo_ff, geo_in;

   always_comb begin
      geo_in.top_lo   = s4_t_ff - half_s;
      geo_in.top_hi   = s4_t_ff - half_s + lw_s;
      geo_in.bot_lo   = s4_b_ff - half_s;
      geo_in.bot_hi   = s4_b_ff - half_s + lw_s;
      geo_in.bar_lo   = s4_t_ff;
      geo_in.bar_hi   = s4_b_ff;
      geo_in.band_lo  = s4_l_ff - half_s;
      geo_in.band_hi  = s4_r_ff - half_s + lw_s;
      geo_in.left_hi  = s4_l_ff - half_s + lw_s;
      geo_in.right_lo = s4_r_ff - half_s;
   end

   always_ff @(posedge clock) begin
      s1_l_ff  <= s1_l_in;
      s1_t_ff  <= s1_t_in;
      s1_r_ff  <= s1_r_in;
      s1_b_ff  <= s1_b_in;
      s2_l_ff  <= s2_l_in;
      s2_t_ff  <= s2_t_in;
      s2_r_ff  <= s2_r_in;
      s2_b_ff  <= s2_b_in;
      s2_rw_ff <= s2_r_in - s2_l_in;
      s2_rh_ff <= s2_b_in - s2_t_in;
      s3_l_ff  <= s3_l_in;
      s3_t_ff  <= s3_t_in;
      s3_r_ff  <= s3_r_in;
      s3_b_ff  <= s3_b_in;
      s4_l_ff  <= s4_l_in;
      s4_t_ff  <= s4_t_in;
      s4_r_ff  <= s4_r_in;
      s4_b_ff  <= s4_b_in;
      geo_ff   <= geo_in;
   end

   assign geo = geo_ff;

endmodule

`default_nettype wire

/* hw/rtl/nvro_front.sv */
// Input side: accepts beats, tracks plane, row and column, tags each byte.
`default_nettype none

module nvro_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [nvro_pkg::BYTE_W-1:0]    req_pixel_byte,
   input  wire logic                           req_frame_start,
   input  wire nvro_pkg::cfg_type              cfg,
   input  wire logic                           settling,
   input  wire logic                           q_full,
   output logic                                push,
   output nvro_pkg::entry_type                 push_entry
);

   localparam int DW = nvro_pkg::DIM_W;

   logic [DW-1:0] col_ff, col_in, row_ff, row_in;
   logic          plane_ff, plane_in;
   logic [DW-1:0] col, row, plane_rows;
   logic          plane, row_end, plane_end, last;

   assign req_stall = q_full || settling;
   assign push      = req_valid && !req_stall;

   always_comb begin
      col   = req_frame_start ? '0 : col_ff;
      row   = req_frame_start ? '0 : row_ff;
      plane = req_frame_start ? 1'b0 : plane_ff;

      plane_rows = plane ? (cfg.frame_height >> 1) : cfg.frame_height;
      row_end    = ({1'b0, col} + 1'b1) >= {1'b0, cfg.frame_width};
      plane_end  = ({1'b0, row} + 1'b1) >= {1'b0, plane_rows};

      col_in   = col + 1'b1;
      row_in   = row;
      plane_in = plane;
      last     = 1'b0;
      if (row_end) begin
         col_in = '0;
         if (plane_end) begin
            row_in   = '0;
            last     = plane;
            plane_in = !plane;
         end else begin
            row_in = row + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= 1'b0;
      end else if (push) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
      end
   end

   assign push_entry.pixel_byte = req_pixel_byte;
   assign push_entry.col        = col;
   assign push_entry.row        = row;
   assign push_entry.chroma     = plane;
   assign push_entry.last       = last;

endmodule

`default_nettype wire

/* hw/rtl/nvro_queue.sv */
// Short flip-flop queue between the front and back parts.
`default_nettype none

module nvro_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nvro_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output nvro_pkg::entry_type        head,
   output nvro_pkg::q_status_type     status
);

   nvro_pkg::entry_type slots_ff [nvro_pkg::QUEUE_DEPTH];
   logic [nvro_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [nvro_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == nvro_pkg::QCNT_W'(nvro_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

`default_nettype wire

/* hw/rtl/nvro_back.sv */
// Output side: border test on the queue head and the result register.
`default_nettype none

module nvro_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire nvro_pkg::entry_type            head,
   input  wire nvro_pkg::q_status_type         q_status,
   input  wire nvro_pkg::geo_type              geo,
   input  wire nvro_pkg::cfg_type              cfg,
   output logic                                pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [nvro_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                rsp_in_chroma,
   output logic                                rsp_frame_end
);

   localparam int CW = nvro_pkg::COORD_W;

   function automatic logic on_border(
      input nvro_pkg::geo_type           g,
      input nvro_pkg::cfg_type           c,
      input logic [nvro_pkg::Y_W-1:0]    y,
      input logic [nvro_pkg::DIM_W-1:0]  x
   );
      logic signed [CW-1:0] yy;
      logic signed [CW-1:0] xx;
      logic                 in_frame, hit_row, hit_band, in_bar, hit_bar;
      yy       = CW'(y);
      xx       = CW'(x);
      in_frame = (y < nvro_pkg::Y_W'(c.frame_height)) && (x < c.frame_width);
      hit_row  = (yy >= g.top_lo && yy < g.top_hi) || (yy >= g.bot_lo && yy < g.bot_hi);
      hit_band = hit_row && (xx >= g.band_lo) && (xx < g.band_hi);
      in_bar   = (yy >= g.bar_lo) && (yy < g.bar_hi);
      hit_bar  = in_bar && (((xx >= g.band_lo) && (xx < g.left_hi)) ||
                            ((xx >= g.right_lo) && (xx < g.band_hi)));
      return in_frame && (hit_band || hit_bar);
   endfunction

   logic                        valid_ff;
   logic [nvro_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        chroma_ff, end_ff;
   logic                        hit_luma, hit_c0, hit_c1;

   assign pop = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      hit_luma = on_border(geo, cfg, {1'b0, head.row}, head.col);
      hit_c0   = on_border(geo, cfg, {head.row, 1'b0}, head.col);
      hit_c1   = on_border(geo, cfg, {head.row, 1'b1}, head.col);
      byte_in  = head.pixel_byte;
      if (head.chroma) begin
         if (hit_c0 || hit_c1) begin
            byte_in = cfg.color_mode ? nvro_pkg::CHROMA_COLOR : nvro_pkg::CHROMA_PLAIN;
         end
      end else if (hit_luma) begin
         byte_in = nvro_pkg::LUMA_BORDER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= byte_in;
         chroma_ff <= head.chroma;
         end_ff    <= head.last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_in_chroma = chroma_ff;
   assign rsp_frame_end = end_ff;

endmodule

`default_nettype wire

/* hw/rtl/nv21_rectangle_overlay_top.sv */
// Top level of the NV21 rectangle border overlay.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   pixel_byte, frame_start
//   rsp      out        rsp_valid/stall   out_byte, in_chroma, frame_end
//   csr      in         csr_wen           csr_index, csr_wdata
//
// One beat per clock while neither stall is raised; the front writes a taken
// req beat into the queue, then the back tests it and registers it on rsp.
// The border intervals come from a five-stage geometry pipeline: after reset
// and after every csr write, req_stall holds high while it refills.
// rsp_stall first fills the four-entry queue, then raises req_stall.
// Reset is synchronous, active high; it clears position and handshake state.
`default_nettype none
`include "assert_macros.svh"

module nv21_rectangle_overlay_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input byte stream
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [nvro_pkg::BYTE_W-1:0]      req_pixel_byte,
   input  wire logic                             req_frame_start,
   // result stream
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [nvro_pkg::BYTE_W-1:0]           rsp_out_byte,
   output logic                                  rsp_in_chroma,
   output logic                                  rsp_frame_end,
   // register writes
   input  wire logic                             csr_wen,
   input  wire logic [nvro_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [nvro_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   nvro_pkg::cfg_type      cfg;
   nvro_pkg::geo_type      geo;
   nvro_pkg::entry_type    push_entry, head;
   nvro_pkg::q_status_type q_status;
   logic                   settling, push, pop;
   logic [nvro_pkg::QCNT_W-1:0] q_cap;

   assign q_cap = nvro_pkg::QCNT_W'(nvro_pkg::QUEUE_DEPTH);

   // register file plus border geometry, recomputed from the live registers
   nvro_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .geo       (geo),
      .settling  (settling)
   );

   // front: position tracking, one tagged entry per accepted beat
   nvro_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_byte  (req_pixel_byte),
      .req_frame_start (req_frame_start),
      .cfg             (cfg),
      .settling        (settling),
      .q_full          (q_status.full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decoupling queue
   nvro_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // back: border test and output register
   nvro_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .geo           (geo),
      .cfg           (cfg),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_in_chroma (rsp_in_chroma),
      .rsp_frame_end (rsp_frame_end)
   );

   // a write must hold off input while the geometry refills
   `ASSERT_NEXT(a_csr_holdoff, clock, reset, csr_wen, !(req_valid && !req_stall), "csr holdoff")
   // frame end only marks a chroma byte
   `ASSERT_IMPL(a_end_chroma, clock, reset, rsp_valid && rsp_frame_end, rsp_in_chroma, "luma end")
   // output only loads from a non-empty queue
   `ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid), $past(!q_status.empty), "no entry")
   // occupancy bound
   `ASSERT_NEVER(a_q_bound, clock, reset, q_status.count > q_cap, "queue overflow")

endmodule

`default_nettype wire

/* tb/nv21_rectangle_overlay_top_test.sv */
// Self-checking testbench for the NV21 rectangle border overlay top level.
module nv21_rectangle_overlay_top_test;
   import nvro_pkg::*;

   // one result beat as the block presents it
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              chroma;
      logic              last;
   } pixel_out;

   // one row of the directed plan: a register write or an input beat
   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [BYTE_W-1:0]     pix;
      logic                  fs;
      bit                    typed;   // want below is fixed, not predicted
      pixel_out              want;
   } plan_row;

   // ---------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ---------------------------------------------------------------
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_pixel_byte  = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_in_chroma;
   logic                  rsp_frame_end;
   logic                  csr_wen         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   nv21_rectangle_overlay_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_byte  (req_pixel_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_in_chroma   (rsp_in_chroma),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Overlay predictor: register copy plus stream position
   // ---------------------------------------------------------------
   logic [DIM_W-1:0]         frame_w      = RST_FRAME_WIDTH;
   logic [DIM_W-1:0]         frame_h      = RST_FRAME_HEIGHT;
   logic signed [RECT_W-1:0] rect_l       = '0;
   logic signed [RECT_W-1:0] rect_t       = '0;
   logic signed [RECT_W-1:0] rect_r       = '0;
   logic signed [RECT_W-1:0] rect_b       = '0;
   logic [LW_W-1:0]          line_w       = RST_LINE_WIDTH;
   logic                     color_on     = 1'b0;
   logic [DIM_W-1:0]         col_pos      = '0;
   logic [DIM_W-1:0]         row_pos      = '0;
   logic                     chroma_plane = 1'b0;

   pixel_out pending_out[$];   // predicted beats not yet seen on rsp
   int  mismatches    = 0;
   int  beats_sent    = 0;
   int  beats_checked = 0;
   int  frames_closed = 0;
   int  settings_used = 0;
   bit  calm          = 1'b0;  // both sides run without gaps while set

   // Border test for luma (y, x) against the current registers.
   function automatic bit on_border(int y, int x);
      int w, hg, lw, h, l, t, r, b, rw, rh;
      w  = int'(frame_w);
      hg = int'(frame_h);
      lw = int'(line_w);
      h  = lw / 2;
      if (y < 0 || y >= hg || x < 0 || x >= w)
         return 1'b0;
      // intersect with the frame, empty rectangle collapses to the origin
      l = int'(rect_l) > 0 ? int'(rect_l) : 0;
      t = int'(rect_t) > 0 ? int'(rect_t) : 0;
      r = int'(rect_r) < w ? int'(rect_r) : w;
      b = int'(rect_b) < hg ? int'(rect_b) : hg;
      if (l >= r || t >= b) begin
         l = 0; t = 0; r = 0; b = 0;
      end
      rw = r - l;
      rh = b - t;
      // shift and clamp by half the line width
      if (t + lw + rh > hg) t = hg - lw - rh;
      if (t < h) t = h;
      if (b - lw < 0) b = lw;
      if (b + h > hg) b = hg - h;
      if (l + lw + rw > w) l = w - lw - rw;
      if (l < h) l = h;
      if (r - lw < 0) r = lw;
      if (r + h > w) r = w - h;
      // top and bottom bands
      if (((y >= t - h && y < t - h + lw) || (y >= b - h && y < b - h + lw)) &&
          x >= l - h && x < r - h + lw)
         return 1'b1;
      // left and right bars
      if (y >= t && y < b &&
          ((x >= l - h && x < l - h + lw) || (x >= r - h && x < r - h + lw)))
         return 1'b1;
      return 1'b0;
   endfunction

   // Predicts the result of one input beat and advances the position.
   function automatic pixel_out overlay_step(logic [BYTE_W-1:0] pix, logic fs);
      pixel_out o;
      int       x, y, rows;
      bit       row_end, plane_end;
      if (fs) begin
         col_pos      = '0;
         row_pos      = '0;
         chroma_plane = 1'b0;
      end
      x        = int'(col_pos);
      y        = int'(row_pos);
      o.value  = pix;
      o.chroma = chroma_plane;
      o.last   = 1'b0;
      if (!chroma_plane) begin
         if (on_border(y, x)) o.value = LUMA_BORDER;
         rows = int'(frame_h);
      end else begin
         // chroma row c covers luma rows 2c and 2c+1
         if (on_border(2 * y, x) || on_border(2 * y + 1, x))
            o.value = color_on ? CHROMA_COLOR : CHROMA_PLAIN;
         rows = int'(frame_h) / 2;
      end
      // "at or beyond" so a shrunk size still ends the row or plane
      row_end   = x + 1 >= int'(frame_w);
      plane_end = y + 1 >= rows;
      if (row_end) begin
         col_pos = '0;
         if (plane_end) begin
            row_pos      = '0;
            o.last       = chroma_plane;
            chroma_plane = ~chroma_plane;
         end else begin
            row_pos = row_pos + 1'b1;
         end
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return o;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH:  frame_w  = data[DIM_W-1:0];
         CSR_FRAME_HEIGHT: frame_h  = data[DIM_W-1:0];
         CSR_RECT_LEFT:    rect_l   = data[RECT_W-1:0];
         CSR_RECT_TOP:     rect_t   = data[RECT_W-1:0];
         CSR_RECT_RIGHT:   rect_r   = data[RECT_W-1:0];
         CSR_RECT_BOTTOM:  rect_b   = data[RECT_W-1:0];
         CSR_LINE_WIDTH:   line_w   = data[LW_W-1:0];
         CSR_COLOR_MODE:   color_on = data[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Directed plan rows
   // ---------------------------------------------------------------
   function automatic plan_row reg_row(logic [CSR_IDX_W-1:0] idx, int data);
      plan_row p;
      p.is_reg = 1'b1;
      p.idx    = idx;
      p.data   = CSR_DATA_W'(data);
      p.pix    = '0;
      p.fs     = 1'b0;
      p.typed  = 1'b0;
      p.want   = '0;
      return p;
   endfunction

   function automatic plan_row beat_row(logic [BYTE_W-1:0] pix, logic fs);
      plan_row p;
      p.is_reg = 1'b0;
      p.idx    = CSR_FRAME_WIDTH;
      p.data   = '0;
      p.pix    = pix;
      p.fs     = fs;
      p.typed  = 1'b0;
      p.want   = '0;
      return p;
   endfunction

   function automatic plan_row typed_row(logic [BYTE_W-1:0] pix, logic fs,
                                         logic [BYTE_W-1:0] value);
      plan_row p;
      p = beat_row(pix, fs);
      p.typed       = 1'b1;
      p.want.value  = value;
      p.want.chroma = 1'b0;
      p.want.last   = 1'b0;
      return p;
   endfunction

   // ---------------------------------------------------------------
   // Drivers: all nonblocking at the rising edge, one assignment per step
   // ---------------------------------------------------------------
   // Drives the register write into the next rising edge; caller lowers csr_wen afterward.
   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic send_beat(logic [BYTE_W-1:0] pix, logic fs, pixel_out want);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_byte  <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_out.push_back(want);
      beats_sent++;
   endtask

   // Sender pauses until every predicted beat has come back.
   task automatic drain_out();
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Rectangle edge near the frame, sometimes at the register extremes.
   function automatic int pick_edge(int span);
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)  return -4096;
      if (roll < 16) return 4095;
      return int'($urandom_range(span + 12, 0)) - 6;
   endfunction

   function automatic int pick_line_width();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 0;
      if (roll < 20) return 255;
      if (roll < 70) return $urandom_range(6, 1);
      return $urandom_range(40, 7);
   endfunction

   // New register setting between phases; first two pin the size extremes.
   task automatic new_setting(int phase);
      int w, hg;
      bit all;
      all = phase < 2;
      if (phase == 0) begin
         w = 4095; hg = 4095;
      end else if (phase == 1) begin
         w = 2; hg = 2;
      end else if ($urandom_range(99) < 8) begin
         w  = $urandom_range(4095, 2);
         hg = $urandom_range(4095, 2);
      end else begin
         w  = $urandom_range(12, 2);
         hg = $urandom_range(9, 2);
      end
      if (all || $urandom_range(99) < 70) set_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      if (all || $urandom_range(99) < 70) set_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(hg));
      if (phase == 0) begin
         set_reg(CSR_RECT_LEFT,   CSR_DATA_W'(-4096));
         set_reg(CSR_RECT_TOP,    CSR_DATA_W'(-4096));
         set_reg(CSR_RECT_RIGHT,  CSR_DATA_W'(4095));
         set_reg(CSR_RECT_BOTTOM, CSR_DATA_W'(4095));
         set_reg(CSR_LINE_WIDTH,  CSR_DATA_W'(255));
         set_reg(CSR_COLOR_MODE,  CSR_DATA_W'(1));
      end else begin
         if (all || $urandom_range(99) < 70)
            set_reg(CSR_RECT_LEFT, CSR_DATA_W'(pick_edge(w)));
         if (all || $urandom_range(99) < 70)
            set_reg(CSR_RECT_TOP, CSR_DATA_W'(pick_edge(hg)));
         if (all || $urandom_range(99) < 70)
            set_reg(CSR_RECT_RIGHT, CSR_DATA_W'(pick_edge(w)));
         if (all || $urandom_range(99) < 70)
            set_reg(CSR_RECT_BOTTOM, CSR_DATA_W'(pick_edge(hg)));
         if (phase == 1)
            set_reg(CSR_LINE_WIDTH, CSR_DATA_W'(1));
         else if ($urandom_range(99) < 70)
            set_reg(CSR_LINE_WIDTH, CSR_DATA_W'(pick_line_width()));
         if (all || $urandom_range(99) < 70)
            set_reg(CSR_COLOR_MODE, CSR_DATA_W'($urandom_range(1)));
      end
      settings_used++;
   endtask

   // ---------------------------------------------------------------
   // Receiver: random stall, quiet during the calm stretch
   // ---------------------------------------------------------------
   always @(posedge clock)
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 29);

   task automatic report_field(string name, logic [BYTE_W-1:0] want_v,
                               logic [BYTE_W-1:0] got_v);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
   endtask

   // Result checker: every taken rsp beat against the oldest prediction.
   always @(posedge clock) begin
      pixel_out want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none actual %0h/%0b/%0b", $time,
                     rsp_out_byte, rsp_in_chroma, rsp_frame_end);
         end else begin
            want = pending_out.pop_front();
            if (rsp_out_byte !== want.value)
               report_field("out_byte", want.value, rsp_out_byte);
            if (rsp_in_chroma !== want.chroma)
               report_field("in_chroma", BYTE_W'(want.chroma), BYTE_W'(rsp_in_chroma));
            if (rsp_frame_end !== want.last)
               report_field("frame_end", BYTE_W'(want.last), BYTE_W'(rsp_frame_end));
            beats_checked++;
            if (rsp_frame_end === 1'b1) frames_closed++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      plan_row  plan[$];
      pixel_out want;
      bit       writing;
      int       phase, count, k;
      logic     fs;
      logic [BYTE_W-1:0] pix;

      writing = 1'b0;
      plan = '{
         // reset geometry: empty rectangle clamps to a 3-wide corner band
         typed_row(8'h12, 1'b1, LUMA_BORDER),
         typed_row(8'h00, 1'b0, LUMA_BORDER),
         typed_row(8'h34, 1'b0, LUMA_BORDER),
         typed_row(8'h56, 1'b0, 8'h56),
         // zero line width: every byte passes
         reg_row(CSR_LINE_WIDTH, 0),
         typed_row(8'h00, 1'b0, 8'h00),
         typed_row(8'hFF, 1'b0, 8'hFF),
         typed_row(8'h0F, 1'b0, 8'h0F),
         typed_row(8'hF0, 1'b0, 8'hF0),
         // smallest frame, rectangle at the register extremes; size shrinks
         // under a running row so the next beat ends that row
         reg_row(CSR_FRAME_WIDTH, 2),
         reg_row(CSR_FRAME_HEIGHT, 2),
         reg_row(CSR_RECT_LEFT, -4096),
         reg_row(CSR_RECT_TOP, -4096),
         reg_row(CSR_RECT_RIGHT, 4095),
         reg_row(CSR_RECT_BOTTOM, 4095),
         reg_row(CSR_LINE_WIDTH, 2),
         reg_row(CSR_COLOR_MODE, 1),
         beat_row(8'h80, 1'b0),
         beat_row(8'h01, 1'b1),
         beat_row(8'h02, 1'b0),
         beat_row(8'h03, 1'b0),
         beat_row(8'h04, 1'b0),
         beat_row(8'h05, 1'b0),
         beat_row(8'h06, 1'b0),
         // odd width, inverted rectangle, widest line: clamps cross over
         reg_row(CSR_RECT_LEFT, 3),
         reg_row(CSR_RECT_RIGHT, 1),
         reg_row(CSR_LINE_WIDTH, 255),
         reg_row(CSR_FRAME_WIDTH, 3),
         reg_row(CSR_COLOR_MODE, 0),
         beat_row(8'hA5, 1'b1),
         beat_row(8'h5A, 1'b0),
         beat_row(8'hC3, 1'b0),
         beat_row(8'h3C, 1'b0),
         beat_row(8'h99, 1'b0),
         beat_row(8'h66, 1'b0),
         beat_row(8'hE7, 1'b0),
         beat_row(8'h18, 1'b0),
         beat_row(8'h7E, 1'b0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk
      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!writing) begin
               drain_out();
               writing = 1'b1;
               settings_used++;
            end
            set_reg(plan[i].idx, plan[i].data);
         end else begin
            if (writing) begin
               csr_wen <= 1'b0;
               writing = 1'b0;
            end
            want = overlay_step(plan[i].pix, plan[i].fs);
            if (plan[i].typed) want = plan[i].want;
            send_beat(plan[i].pix, plan[i].fs, want);
         end
      end

      // random phases: new setting while idle, then a run of stream beats;
      // mostly well-formed frames, now and then a stray frame start
      phase = 0;
      while (beats_sent < 1650) begin
         drain_out();
         new_setting(phase);
         csr_wen <= 1'b0;
         count = phase == 0 ? 40 : $urandom_range(150, 20);
         for (k = 0; k < count; k++) begin
            if (col_pos == '0 && row_pos == '0 && !chroma_plane)
               fs = $urandom_range(99) < 50;
            else
               fs = $urandom_range(99) < 2;
            pix  = BYTE_W'($urandom_range(255));
            calm = beats_sent >= 700 && beats_sent < 1000;
            want = overlay_step(pix, fs);
            send_beat(pix, fs, want);
         end
         calm = 1'b0;
         phase++;
      end

      drain_out();
      repeat (10) @(posedge clock);
      $display("checked %0d beats across %0d register settings, %0d frames closed",
               beats_checked, settings_used, frames_closed);
      $display("frames 2x2 up to 4095x4095, line widths 0 to 255, both chroma colors");
      if (mismatches == 0)
         $display("nv21_rectangle_overlay_top test passed");
      else
         $display("nv21_rectangle_overlay_top test failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("nv21_rectangle_overlay_top test failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nvro_pkg.sv
hw/rtl/nvro_geometry.sv
hw/rtl/nvro_front.sv
hw/rtl/nvro_queue.sv
hw/rtl/nvro_back.sv
hw/rtl/nv21_rectangle_overlay_top.sv
tb/nv21_rectangle_overlay_top_test.sv
